// File: rtl/ssqt_pkg.sv
// ssqt_pkg: shared types and constants of the single-server queue tick block
// used by ssqt_ctrl, ssqt_datapath and single_server_queue_tick_top
// no dependencies
`default_nettype none

package ssqt_pkg;

    // generator constants
    localparam logic [31:0] LCG_MUL = 32'd843314861;
    localparam logic [31:0] LCG_ADD = 32'd453816693;

    // configuration register reset values
    localparam logic [31:0] THRESH_RESET = 32'd715827883;
    localparam logic [31:0] LIMIT_RESET  = 32'd78665070;
    localparam logic [30:0] SEED_RESET   = 31'd1234556;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POISSON_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_SEED      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SERVICE_SEED      = 2'd3;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARR_STEP,
        ST_ARR_CHK,
        ST_SERVE,
        ST_PROD_INIT,
        ST_DRAW_CHK,
        ST_DRAW_STEP,
        ST_PROD_MUL,
        ST_SUM,
        ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clear_run;   // reload seeds, clear counters
        logic tick_start;  // step arrival generator, count tick, decrement timer
        logic arr_update;  // apply arrival compare
        logic draw_start;  // dequeue, first service generator step, clear count
        logic prod_init;   // product from first uniform
        logic draw_step;   // service generator step, count up
        logic prod_mul;    // product times uniform
        logic timer_load;  // timer takes the drawn count
        logic sum_update;  // add queue length to total
        logic out_load;    // load output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic serve_needed; // server idle and queue not empty
        logic draw_more;    // product not below limit and count below bound
    } status_t;

endpackage

`default_nettype wire

// File: rtl/ssqt_ctrl.sv
// ssqt_ctrl: sequencing state machine of the queue tick block
// depends on ssqt_pkg (state, command and status types)
`default_nettype none

module ssqt_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_restart,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire ssqt_pkg::status_t status,
    output ssqt_pkg::cmd_t        cmd
);

    ssqt_pkg::state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ssqt_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ssqt_pkg::ST_IDLE: begin
                if (s_valid) state_next = ssqt_pkg::ST_ARR_STEP;
            end
            ssqt_pkg::ST_ARR_STEP: state_next = ssqt_pkg::ST_ARR_CHK;
            ssqt_pkg::ST_ARR_CHK:  state_next = ssqt_pkg::ST_SERVE;
            ssqt_pkg::ST_SERVE: begin
                state_next = status.serve_needed ? ssqt_pkg::ST_PROD_INIT : ssqt_pkg::ST_SUM;
            end
            ssqt_pkg::ST_PROD_INIT: state_next = ssqt_pkg::ST_DRAW_CHK;
            ssqt_pkg::ST_DRAW_CHK: begin
                state_next = status.draw_more ? ssqt_pkg::ST_DRAW_STEP : ssqt_pkg::ST_SUM;
            end
            ssqt_pkg::ST_DRAW_STEP: state_next = ssqt_pkg::ST_PROD_MUL;
            ssqt_pkg::ST_PROD_MUL:  state_next = ssqt_pkg::ST_DRAW_CHK;
            ssqt_pkg::ST_SUM:       state_next = ssqt_pkg::ST_OUT;
            ssqt_pkg::ST_OUT: begin
                if (out_free) state_next = ssqt_pkg::ST_IDLE;
            end
            default: state_next = ssqt_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ssqt_pkg::ST_IDLE:      cmd.clear_run = s_valid && s_restart;
            ssqt_pkg::ST_ARR_STEP:  cmd.tick_start = 1'b1;
            ssqt_pkg::ST_ARR_CHK:   cmd.arr_update = 1'b1;
            ssqt_pkg::ST_SERVE:     cmd.draw_start = status.serve_needed;
            ssqt_pkg::ST_PROD_INIT: cmd.prod_init = 1'b1;
            ssqt_pkg::ST_DRAW_CHK:  cmd.timer_load = !status.draw_more;
            ssqt_pkg::ST_DRAW_STEP: cmd.draw_step = 1'b1;
            ssqt_pkg::ST_PROD_MUL:  cmd.prod_mul = 1'b1;
            ssqt_pkg::ST_SUM:       cmd.sum_update = 1'b1;
            ssqt_pkg::ST_OUT:       cmd.out_load = out_free;
            default:                cmd = '0;
        endcase
    end

    // result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (cmd.out_load)           m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ssqt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ssqt_datapath.sv
// ssqt_datapath: generators, queue state, Poisson product and result register
// depends on ssqt_pkg (command and status types, constants)
`default_nettype none

module ssqt_datapath #(
    parameter int              MAX_SERVICE = 63,
    parameter longint unsigned QUEUE_MAX   = 65535
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ssqt_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  wire logic [31:0]                       cfg_wr_data,
    input  wire ssqt_pkg::cmd_t                    cmd,
    output ssqt_pkg::status_t                      status,
    output logic [31:0]                            m_tick_number,
    output logic                                   m_arrived,
    output logic [15:0]                            m_queue_length,
    output logic [5:0]                             m_service_left,
    output logic [31:0]                            m_total_queue,
    output logic [31:0]                            m_total_arrivals
);

    localparam int QW = $clog2(QUEUE_MAX + 64'd1);
    localparam int CW = $clog2(MAX_SERVICE + 1);
    localparam logic [QW-1:0] QMAX = QW'(QUEUE_MAX);
    localparam logic [CW-1:0] CMAX = CW'(MAX_SERVICE);

    // configuration registers
    logic [31:0] thresh_reg, thresh_next;
    logic [31:0] limit_reg, limit_next;
    logic [30:0] arr_seed_reg, arr_seed_next;
    logic [30:0] svc_seed_reg, svc_seed_next;

    // simulation state
    logic [30:0] arr_rng_reg, arr_rng_next;
    logic [30:0] svc_rng_reg, svc_rng_next;
    logic [QW-1:0] waiting_reg, waiting_next;
    logic [CW-1:0] timer_reg, timer_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] qsum_reg, qsum_next;
    logic [31:0] asum_reg, asum_next;
    logic        arrived_reg, arrived_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0] prod_reg, prod_next;

    // shared generator step and product multiplier
    logic [30:0] lcg_in;
    logic [31:0] lcg_full;
    logic [62:0] prod_full;
    logic [32:0] qsum_wide;
    logic [31:0] waiting_ext;
    logic [31:0] timer_ext;

    assign lcg_in    = cmd.tick_start ? arr_rng_reg : svc_rng_reg;
    assign lcg_full  = {1'b0, lcg_in} * ssqt_pkg::LCG_MUL + ssqt_pkg::LCG_ADD;
    assign prod_full = 63'(prod_reg) * 63'(svc_rng_reg);
    assign waiting_ext = 32'(waiting_reg);
    assign timer_ext   = 32'(timer_reg);
    assign qsum_wide = {1'b0, qsum_reg} + {1'b0, waiting_ext};

    assign status.serve_needed = (timer_reg == '0) && (waiting_reg != '0);
    assign status.draw_more    = (prod_reg >= limit_reg) && (count_reg < CMAX);

    // next-state logic
    always_comb begin
        thresh_next   = thresh_reg;
        limit_next    = limit_reg;
        arr_seed_next = arr_seed_reg;
        svc_seed_next = svc_seed_reg;
        arr_rng_next  = arr_rng_reg;
        svc_rng_next  = svc_rng_reg;
        waiting_next  = waiting_reg;
        timer_next    = timer_reg;
        tick_next     = tick_reg;
        qsum_next     = qsum_reg;
        asum_next     = asum_reg;
        arrived_next  = arrived_reg;
        count_next    = count_reg;
        prod_next     = prod_reg;

        // register writes
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                ssqt_pkg::REG_ARRIVAL_THRESHOLD: thresh_next   = cfg_wr_data;
                ssqt_pkg::REG_POISSON_LIMIT:     limit_next    = cfg_wr_data;
                ssqt_pkg::REG_ARRIVAL_SEED:      arr_seed_next = cfg_wr_data[30:0];
                ssqt_pkg::REG_SERVICE_SEED:      svc_seed_next = cfg_wr_data[30:0];
                default: ;
            endcase
        end

        // restart of the run
        if (cmd.clear_run) begin
            arr_rng_next = arr_seed_reg;
            svc_rng_next = svc_seed_reg;
            waiting_next = '0;
            timer_next   = '0;
            tick_next    = '0;
            qsum_next    = '0;
            asum_next    = '0;
        end

        // arrival generator, tick count and timer countdown
        if (cmd.tick_start) begin
            arr_rng_next = lcg_full[30:0];
            tick_next    = (tick_reg == '1) ? tick_reg : tick_reg + 32'd1;
            if (timer_reg != '0) timer_next = timer_reg - CW'(1);
        end

        // arrival decision
        if (cmd.arr_update) begin
            arrived_next = ({1'b0, arr_rng_reg} < thresh_reg);
            if ({1'b0, arr_rng_reg} < thresh_reg) begin
                asum_next = (asum_reg == '1) ? asum_reg : asum_reg + 32'd1;
                if (waiting_reg < QMAX) waiting_next = waiting_reg + QW'(1);
            end
        end

        // dequeue and first uniform
        if (cmd.draw_start) begin
            waiting_next = waiting_reg - QW'(1);
            svc_rng_next = lcg_full[30:0];
            count_next   = '0;
        end

        if (cmd.prod_init) prod_next = {svc_rng_reg, 1'b0};

        // further uniforms
        if (cmd.draw_step) begin
            svc_rng_next = lcg_full[30:0];
            count_next   = count_reg + CW'(1);
        end

        if (cmd.prod_mul)   prod_next  = prod_full[62:31];
        if (cmd.timer_load) timer_next = count_reg;

        // saturating queue total
        if (cmd.sum_update) qsum_next = qsum_wide[32] ? 32'hFFFF_FFFF : qsum_wide[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg   <= ssqt_pkg::THRESH_RESET;
            limit_reg    <= ssqt_pkg::LIMIT_RESET;
            arr_seed_reg <= ssqt_pkg::SEED_RESET;
            svc_seed_reg <= ssqt_pkg::SEED_RESET;
            arr_rng_reg  <= ssqt_pkg::SEED_RESET;
            svc_rng_reg  <= ssqt_pkg::SEED_RESET;
            waiting_reg  <= '0;
            timer_reg    <= '0;
            tick_reg     <= '0;
            qsum_reg     <= '0;
            asum_reg     <= '0;
        end else begin
            thresh_reg   <= thresh_next;
            limit_reg    <= limit_next;
            arr_seed_reg <= arr_seed_next;
            svc_seed_reg <= svc_seed_next;
            arr_rng_reg  <= arr_rng_next;
            svc_rng_reg  <= svc_rng_next;
            waiting_reg  <= waiting_next;
            timer_reg    <= timer_next;
            tick_reg     <= tick_next;
            qsum_reg     <= qsum_next;
            asum_reg     <= asum_next;
        end
    end

    // working registers, no reset
    always_ff @(posedge aclk) begin
        arrived_reg <= arrived_next;
        count_reg   <= count_next;
        prod_reg    <= prod_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tick_number    <= tick_reg;
            m_arrived        <= arrived_reg;
            m_queue_length   <= waiting_ext[15:0];
            m_service_left   <= timer_ext[5:0];
            m_total_queue    <= qsum_reg;
            m_total_arrivals <= asum_reg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/single_server_queue_tick_top.sv
// single_server_queue_tick_top: top level of the discrete-time single-server queue
// depends on ssqt_pkg, ssqt_ctrl and ssqt_datapath
//
// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    s_restart
// m_        out        m_valid/m_ready    tick, arrival flag, queue, timer, totals
// cfg_      in         cfg_wr_en          cfg_wr_index, cfg_wr_data
//
// a request accepted in IDLE passes ARR_STEP, ARR_CHK and SERVE, then SUM and OUT; when
// a customer starts service, PROD_INIT and then the draw loop (generator step, product
// multiply, limit compare) for each drawn count come between SERVE and SUM; the result
// is valid, and s_ready rises for the next request, once OUT loads the result register
// the result register lets the next request in while a result waits for m_ready
// reset restores register defaults and reloads both generators from the seeds
`default_nettype none

module single_server_queue_tick_top #(
    parameter int              MAX_SERVICE = 63,
    parameter longint unsigned QUEUE_MAX   = 65535
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_restart,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [31:0]                         m_tick_number,
    output logic                                m_arrived,
    output logic [15:0]                         m_queue_length,
    output logic [5:0]                          m_service_left,
    output logic [31:0]                         m_total_queue,
    output logic [31:0]                         m_total_arrivals,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ssqt_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [31:0]                    cfg_wr_data
);

    ssqt_pkg::cmd_t    cmd;
    ssqt_pkg::status_t status;

    // sequencer
    ssqt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    ssqt_datapath #(
        .MAX_SERVICE (MAX_SERVICE),
        .QUEUE_MAX   (QUEUE_MAX)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .cmd              (cmd),
        .status           (status),
        .m_tick_number    (m_tick_number),
        .m_arrived        (m_arrived),
        .m_queue_length   (m_queue_length),
        .m_service_left   (m_service_left),
        .m_total_queue    (m_total_queue),
        .m_total_arrivals (m_total_arrivals)
    );

endmodule

`default_nettype wire

// File: tb/sv/tb_single_server_queue_tick_top.sv
// tb_single_server_queue_tick_top: self-checking testbench of the single-server queue tick block
// predicts every tick result from its own queue model and checks the m_ side against it
// depends on ssqt_pkg and single_server_queue_tick_top
module tb_single_server_queue_tick_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF      = 6;
    localparam int unsigned MAX_SERVICE   = 63;
    localparam int unsigned QUEUE_MAX     = 65535;
    localparam logic [31:0] GEN_MUL       = 32'd843314861;
    localparam logic [31:0] GEN_ADD       = 32'd453816693;
    localparam logic [31:0] DEF_THRESHOLD = 32'd715827883;
    localparam logic [31:0] DEF_LIMIT     = 32'd78665070;
    localparam logic [31:0] DEF_SEED      = 32'd1234556;
    // slowest quiet stretch is the long receiver hold-off plus one full draw
    localparam int unsigned STALL_LIMIT    = 2000;
    localparam int unsigned SETTLE_CYCLES  = 250;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned RANDOM_ITEMS   = 540;
    // ticks of the closing run with an arrival every tick against 63-tick service
    localparam int unsigned FILL_TICKS     = 60;

    typedef struct packed {
        logic [31:0] tick_number;
        logic        arrived;
        logic [15:0] queue_length;
        logic [5:0]  service_left;
        logic [31:0] total_queue;
        logic [31:0] total_arrivals;
    } tick_report_t;

    logic                               aclk         = 1'b0;
    logic                               aresetn      = 1'b0;
    logic                               s_valid      = 1'b0;
    logic                               s_restart    = 1'b0;
    logic                               m_ready      = 1'b0;
    logic                               cfg_wr_en    = 1'b0;
    logic [ssqt_pkg::CFG_IDX_W-1:0]     cfg_wr_index = '0;
    logic [31:0]                        cfg_wr_data  = '0;
    logic                               s_ready;
    logic                               m_valid;
    logic [31:0]                        m_tick_number;
    logic                               m_arrived;
    logic [15:0]                        m_queue_length;
    logic [5:0]                         m_service_left;
    logic [31:0]                        m_total_queue;
    logic [31:0]                        m_total_arrivals;

    // queue model: settings and run state
    logic [31:0]  cfg_threshold;
    logic [31:0]  cfg_limit;
    logic [30:0]  cfg_arrival_seed;
    logic [30:0]  cfg_service_seed;
    logic [30:0]  gen_arrival;
    logic [30:0]  gen_service;
    int unsigned  waiting;
    int unsigned  svc_timer;
    logic [31:0]  tick_total;
    logic [31:0]  queue_total;
    logic [31:0]  arrival_total;

    tick_report_t expected_ticks[$];
    int unsigned  mismatches      = 0;
    bit           tx_quiet        = 1'b0;
    bit           rx_quiet        = 1'b0;
    int unsigned  holdoff_request = 0;
    int unsigned  rx_hold         = 0;

    single_server_queue_tick_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_restart        (s_restart),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_tick_number    (m_tick_number),
        .m_arrived        (m_arrived),
        .m_queue_length   (m_queue_length),
        .m_service_left   (m_service_left),
        .m_total_queue    (m_total_queue),
        .m_total_arrivals (m_total_arrivals),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // 31-bit generator step
    function automatic logic [30:0] lcg_advance(input logic [30:0] x);
        logic [31:0] t;
        t = {1'b0, x} * GEN_MUL + GEN_ADD;
        return t[30:0];
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // reload generators from the seeds, clear queue, timer and totals
    function automatic void restart_run();
        gen_arrival   = cfg_arrival_seed;
        gen_service   = cfg_service_seed;
        waiting       = 0;
        svc_timer     = 0;
        tick_total    = '0;
        queue_total   = '0;
        arrival_total = '0;
    endfunction

    // one tick of the queue: arrival, timer countdown, service start, totals
    function automatic void predict_tick(input logic restart);
        tick_report_t report;
        logic         arrived;
        int unsigned  draws;
        logic [63:0]  prod;
        if (restart) begin
            restart_run();
        end
        tick_total  = add_sat(tick_total, 32'd1);
        gen_arrival = lcg_advance(gen_arrival);
        arrived     = ({1'b0, gen_arrival} < cfg_threshold);
        if (arrived) begin
            arrival_total = add_sat(arrival_total, 32'd1);
            if (waiting < QUEUE_MAX) begin
                waiting++;
            end
        end
        if (svc_timer > 0) begin
            svc_timer--;
        end
        // poisson draw by product of uniforms, count bounded by MAX_SERVICE
        if (svc_timer == 0 && waiting != 0) begin
            waiting--;
            draws       = 0;
            gen_service = lcg_advance(gen_service);
            prod        = {32'b0, gen_service, 1'b0};
            while (prod >= {32'b0, cfg_limit} && draws < MAX_SERVICE) begin
                gen_service = lcg_advance(gen_service);
                prod        = (prod * {33'b0, gen_service}) >> 31;
                draws++;
            end
            svc_timer = draws;
        end
        queue_total = add_sat(queue_total, waiting);
        report.tick_number    = tick_total;
        report.arrived        = arrived;
        report.queue_length   = waiting[15:0];
        report.service_left   = svc_timer[5:0];
        report.total_queue    = queue_total;
        report.total_arrivals = arrival_total;
        expected_ticks.push_back(report);
    endfunction

    // send one tick request and model it once accepted
    task automatic send_tick(input logic restart);
        int unsigned gap;
        s_valid   <= 1'b1;
        s_restart <= restart;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_tick(restart);
        if (!tx_quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid   <= 1'b0;
            s_restart <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop offering and wait until every expected result is back
    task automatic wait_drained();
        if (s_valid) begin
            s_valid <= 1'b0;
        end
        while (expected_ticks.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // write all four registers while the block is idle
    task automatic apply_settings(input logic [31:0] threshold, input logic [31:0] limit,
                                  input logic [31:0] arrival_seed,
                                  input logic [31:0] service_seed);
        logic [ssqt_pkg::CFG_IDX_W-1:0] regs [4];
        logic [31:0]                    values [4];
        regs   = '{ssqt_pkg::REG_ARRIVAL_THRESHOLD, ssqt_pkg::REG_POISSON_LIMIT,
                   ssqt_pkg::REG_ARRIVAL_SEED, ssqt_pkg::REG_SERVICE_SEED};
        values = '{threshold, limit, arrival_seed, service_seed};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= regs[i];
            cfg_wr_data  <= values[i];
            @(posedge aclk);
        end
        cfg_wr_en        <= 1'b0;
        cfg_threshold    = threshold;
        cfg_limit        = limit;
        cfg_arrival_seed = arrival_seed[30:0];
        cfg_service_seed = service_seed[30:0];
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (holdoff_request != 0) begin
            rx_hold         = holdoff_request;
            holdoff_request = 0;
        end else if (rx_hold == 0 && !rx_quiet && $urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(1, 12);
        end
        if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest expected tick
    always @(posedge aclk) begin : result_check
        tick_report_t seen;
        tick_report_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_tick_number, m_arrived, m_queue_length, m_service_left,
                     m_total_queue, m_total_arrivals};
            if (expected_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with nothing expected, tick %0d", $realtime,
                             seen.tick_number);
                end
            end else begin
                want = expected_ticks.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: mismatch expected tick %0d arr %0d queue %0d",
                                 $realtime, want.tick_number, want.arrived,
                                 want.queue_length,
                                 " timer %0d qsum %0d asum %0d", want.service_left,
                                 want.total_queue, want.total_arrivals);
                        $display("%0t:          actual tick %0d arr %0d queue %0d",
                                 $realtime, seen.tick_number, seen.arrived,
                                 seen.queue_length,
                                 " timer %0d qsum %0d asum %0d", seen.service_left,
                                 seen.total_queue, seen.total_arrivals);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no request or result accepted
    initial begin : watchdog
        int unsigned stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("tb_single_server_queue_tick_top: FAIL");
        $finish;
    end

    // ticks with the register defaults left by reset
    task automatic test_reset_state();
        repeat (6) send_tick(1'b0);
        wait_drained();
    endtask

    // no arrivals at threshold zero, an arrival every tick at and above 2^31
    task automatic test_arrival_extremes();
        apply_settings(32'h0, DEF_LIMIT, DEF_SEED, DEF_SEED);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        wait_drained();
        apply_settings(32'h8000_0000, DEF_LIMIT, DEF_SEED, DEF_SEED);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        wait_drained();
        apply_settings(32'hFFFF_FFFF, DEF_LIMIT, DEF_SEED, DEF_SEED);
        repeat (2) send_tick(1'b0);
        wait_drained();
    endtask

    // limit zero runs every draw to the bound, all-ones limit gives zero draws
    task automatic test_draw_extremes();
        apply_settings(32'h8000_0000, 32'h0, DEF_SEED, DEF_SEED);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        wait_drained();
        apply_settings(32'h8000_0000, 32'hFFFF_FFFF, DEF_SEED, DEF_SEED);
        repeat (2) send_tick(1'b0);
        wait_drained();
    endtask

    // seed writes take effect only on restart, seed bit 31 is dropped
    task automatic test_seed_reload();
        apply_settings(DEF_THRESHOLD, DEF_LIMIT, 32'hFFFF_FFFF, 32'h8000_0001);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_drained();
        apply_settings(DEF_THRESHOLD, DEF_LIMIT, 32'h0, 32'h0);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_drained();
    endtask

    // random settings per phase, random restarts, idling on both sides
    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned phase;
        int unsigned phase_len;
        logic [31:0] threshold;
        logic [31:0] limit;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            case ($urandom_range(0, 5))
                0:       threshold = 32'h0;
                1:       threshold = 32'h8000_0000;
                2:       threshold = $urandom;
                default: threshold = $urandom_range(32'h0800_0000, 32'h7000_0000);
            endcase
            case ($urandom_range(0, 5))
                0:       limit = 32'h0;
                1:       limit = 32'hFFFF_FFFF;
                2:       limit = $urandom;
                default: limit = $urandom_range(32'h0004_0000, 32'h6000_0000);
            endcase
            apply_settings(threshold, limit, $urandom, $urandom);
            tx_quiet  = (phase % 4 == 3);
            rx_quiet  = tx_quiet;
            phase_len = $urandom_range(30, 80);
            for (int i = 0; i < phase_len; i++) begin
                // sender pauses once until every result is back
                if (phase == 2 && i == phase_len / 2) begin
                    wait_drained();
                end
                send_tick(i == 0 || $urandom_range(0, 15) == 0);
            end
            sent += phase_len;
            phase++;
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        wait_drained();
    endtask

    // long receiver hold-off while requests keep coming, block must stall its input
    task automatic test_output_stall();
        apply_settings(DEF_THRESHOLD, DEF_LIMIT, $urandom, $urandom);
        tx_quiet        = 1'b1;
        holdoff_request = HOLDOFF_CYCLES;
        send_tick(1'b1);
        repeat (11) send_tick(1'b0);
        tx_quiet = 1'b0;
        wait_drained();
    endtask

    // arrival every tick against 63-tick service so the queue keeps growing, no idling
    task automatic test_queue_full();
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        apply_settings(32'h8000_0000, 32'h0, $urandom, $urandom);
        send_tick(1'b1);
        repeat (FILL_TICKS - 1) send_tick(1'b0);
        wait_drained();
    endtask

    initial begin
        cfg_threshold    = DEF_THRESHOLD;
        cfg_limit        = DEF_LIMIT;
        cfg_arrival_seed = DEF_SEED[30:0];
        cfg_service_seed = DEF_SEED[30:0];
        restart_run();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_arrival_extremes();
        test_draw_extremes();
        test_seed_reload();
        test_random_traffic();
        test_output_stall();
        test_queue_full();

        // let any stray result show up
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_ticks.size() == 0) begin
            $display("tb_single_server_queue_tick_top: PASS");
        end else begin
            $display("tb_single_server_queue_tick_top: FAIL");
        end
        $finish;
    end

endmodule
